[rtl/cht_pkg.sv]
// Package for the chained hash table: command and status codes, record type,
// bucket mapping. No dependencies.
package cht_pkg;

   localparam int NUM_BUCKETS = 10;
   localparam int KEY_W       = 7;
   localparam int MARKS_W     = 16;
   localparam int NAME_W      = 64;
   localparam int BUCKET_W    = 4;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_SEARCH_ALT = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL     = 2'd2,
      ST_UNUSED   = 2'd3
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [MARKS_W-1:0] marks;
      logic [NAME_W-1:0]  w0;
      logic [NAME_W-1:0]  w1;
      logic [NAME_W-1:0]  w2;
      logic [NAME_W-1:0]  w3;
   } record_type;

   // ones digit by compare and subtract of 100, 80, 40, 20, 10; mapped to a bucket
   function automatic logic [BUCKET_W-1:0] bucket_of(input logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] r;
      r = key;
      if (r >= 7'd100) r = r - 7'd100;
      if (r >= 7'd80)  r = r - 7'd80;
      if (r >= 7'd40)  r = r - 7'd40;
      if (r >= 7'd20)  r = r - 7'd20;
      if (r >= 7'd10)  r = r - 7'd10;
      return (r == '0) ? BUCKET_W'(9) : BUCKET_W'(r - 7'd1);
   endfunction

endpackage

[rtl/cht_store.sv]
// Record memory of the chained hash table: one synchronous memory, one
// write and one registered read port. Depends on cht_pkg.
module cht_store #(
   parameter int DEPTH = 80,
   parameter int AW    = 7
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  cht_pkg::record_type    wr_data,
   input  logic [AW-1:0]          rd_addr,
   output cht_pkg::record_type    rd_data
);
   import cht_pkg::*;

   record_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/chained_hash_table.sv]
// Chained hash table with ten buckets of CHAIN_DEPTH records each.
// Usage: drive req_* and pulse start while busy is low; the item is taken at
// that edge. One result per item appears on rsp_* for one cycle with
// rsp_valid high; it cannot be held off.
// Insert and a miss on an empty chain go straight from the chain-length
// lookup to the result; search and delete walk the chain slot by slot, a
// miss walks the whole chain, and delete moves each record behind the match
// down one slot. Every record read goes through the one read port of the
// record memory, read then compare (or read then write back).
// The result shows in the last busy cycle.
// busy stays high from acceptance to the cycle the result shows.
// Reset (synchronous, active high) clears the chain lengths; record memory
// is not cleared, only slots below a chain's length are ever read.
// Depends on cht_pkg and cht_store.
module chained_hash_table #(
   parameter int CHAIN_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [6:0]  req_record_key,
   input  logic signed [15:0] req_marks_in,
   input  logic [63:0] req_name_in_w0,
   input  logic [63:0] req_name_in_w1,
   input  logic [63:0] req_name_in_w2,
   input  logic [63:0] req_name_in_w3,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_bucket,
   output logic [6:0]  rsp_found_key,
   output logic signed [15:0] rsp_marks_out,
   output logic [63:0] rsp_name_out_w0,
   output logic [63:0] rsp_name_out_w1,
   output logic [63:0] rsp_name_out_w2,
   output logic [63:0] rsp_name_out_w3
);
   import cht_pkg::*;

   localparam int SLOTS = NUM_BUCKETS * CHAIN_DEPTH;
   localparam int AW    = $clog2(SLOTS);
   localparam int LW    = $clog2(CHAIN_DEPTH + 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_LOOK  = 6'b000010,
      S_READ  = 6'b000100,
      S_CMP   = 6'b001000,
      S_SHIFT = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [LW-1:0] len_ff [NUM_BUCKETS];
   logic [LW-1:0] cur_len_ff, cur_len_in;
   logic [LW-1:0] idx_ff, idx_in;
   cmd_type cmd_ff, cmd_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [BUCKET_W-1:0] bkt_ff, bkt_in;
   record_type rec_ff, rec_in;
   status_type st_ff, st_in;
   logic hit_ff, hit_in;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr, base;
   record_type wr_data, rd_data;
   logic len_we;
   logic [LW-1:0] len_wval;

   assign base = AW'(bkt_ff * CHAIN_DEPTH);

   cht_store #(.DEPTH(SLOTS), .AW(AW)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // sequencer
   always_comb begin
      state_in   = state_ff;
      cur_len_in = cur_len_ff;
      idx_in     = idx_ff;
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      bkt_in     = bkt_ff;
      rec_in     = rec_ff;
      st_in      = st_ff;
      hit_in     = hit_ff;
      wr_en      = 1'b0;
      wr_addr    = base + AW'(idx_ff);
      wr_data    = rec_ff;
      rd_addr    = base + AW'(idx_ff);
      len_we     = 1'b0;
      len_wval   = cur_len_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in = cmd_type'(req_cmd);
               key_in = req_record_key;
               bkt_in = bucket_of(req_record_key);
               rec_in = '{key: req_record_key, marks: req_marks_in,
                          w0: req_name_in_w0, w1: req_name_in_w1,
                          w2: req_name_in_w2, w3: req_name_in_w3};
               idx_in = '0;
               hit_in = 1'b0;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            cur_len_in = len_ff[bkt_ff];
            if (cmd_ff == CMD_INSERT) begin
               if (len_ff[bkt_ff] >= LW'(CHAIN_DEPTH)) begin
                  st_in = ST_FULL;
               end else begin
                  st_in    = ST_OK;
                  wr_en    = 1'b1;
                  wr_addr  = base + AW'(len_ff[bkt_ff]);
                  len_we   = 1'b1;
                  len_wval = len_ff[bkt_ff] + LW'(1);
               end
               state_in = S_DONE;
            end else if (len_ff[bkt_ff] == '0) begin
               st_in = ST_NOT_FOUND;
               state_in = S_DONE;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_CMP;
         S_CMP: begin
            if (!hit_ff && rd_data.key == key_ff) begin
               hit_in = 1'b1;
               st_in  = ST_OK;
               if (cmd_ff == CMD_DELETE) begin
                  if (idx_ff + LW'(1) < cur_len_ff) begin
                     idx_in = idx_ff + LW'(1);
                     state_in = S_SHIFT;
                  end else begin
                     len_we = 1'b1;
                     len_wval = cur_len_ff - LW'(1);
                     state_in = S_DONE;
                  end
               end else begin
                  rec_in = rd_data;
                  state_in = S_DONE;
               end
            end else if (hit_ff) begin
               // rd_data holds slot idx; move it down one
               wr_en   = 1'b1;
               wr_addr = base + AW'(idx_ff) - AW'(1);
               wr_data = rd_data;
               if (idx_ff + LW'(1) < cur_len_ff) begin
                  idx_in = idx_ff + LW'(1);
                  state_in = S_SHIFT;
               end else begin
                  len_we = 1'b1;
                  len_wval = cur_len_ff - LW'(1);
                  state_in = S_DONE;
               end
            end else if (idx_ff + LW'(1) < cur_len_ff) begin
               idx_in = idx_ff + LW'(1);
               state_in = S_SHIFT;
            end else begin
               st_in = ST_NOT_FOUND;
               state_in = S_DONE;
            end
         end
         S_SHIFT: state_in = S_CMP;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // S_SHIFT and S_READ both issue a read of slot idx via rd_addr default

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < NUM_BUCKETS; i++) len_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (len_we) len_ff[bkt_ff] <= len_wval;
      end
      cur_len_ff <= cur_len_in;
      idx_ff     <= idx_in;
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      bkt_ff     <= bkt_in;
      rec_ff     <= rec_in;
      st_ff      <= st_in;
      hit_ff     <= hit_in;
   end

   // result ports
   logic show_rec, show_key;
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_status = st_ff;
   assign rsp_bucket = bkt_ff;
   assign show_key  = (st_ff == ST_OK);
   assign show_rec  = show_key && (cmd_ff == CMD_SEARCH || cmd_ff == CMD_SEARCH_ALT);
   assign rsp_found_key   = show_key ? (show_rec ? rec_ff.key : key_ff) : '0;
   assign rsp_marks_out   = show_rec ? rec_ff.marks : '0;
   assign rsp_name_out_w0 = show_rec ? rec_ff.w0 : '0;
   assign rsp_name_out_w1 = show_rec ? rec_ff.w1 : '0;
   assign rsp_name_out_w2 = show_rec ? rec_ff.w2 : '0;
   assign rsp_name_out_w3 = show_rec ? rec_ff.w3 : '0;
endmodule

[rtl/cht_checker.sv]
// Port-level checker for chained_hash_table, bound to the top level.
// Depends on cht_pkg.
module cht_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_status,
   input logic [3:0] rsp_bucket,
   input logic [6:0] rsp_found_key
);
   import cht_pkg::*;

   // an accepted item makes the block busy next cycle
   a_take: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("item not taken");

   // a result ends the busy period
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after result");

   // a result only while busy
   a_vb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");

   // bucket always in range, full or miss report key zero
   a_bkt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bucket <= 4'd9)) else $error("bad bucket");
   a_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_found_key == '0))
      else $error("key on failure");
endmodule

bind chained_hash_table cht_checker u_cht_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_bucket(rsp_bucket),
   .rsp_found_key(rsp_found_key)
);

[bench/tb.sv]
// Self-checking bench for chained_hash_table: drives insert/delete/search items
// and compares each result against an in-bench chained table predictor.
// Depends on cht_pkg and the chained_hash_table RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cht_pkg::*;

   localparam int DEPTH = 8;

   typedef struct {
      status_type         status;
      logic [3:0]         bucket;
      logic [6:0]         key;
      logic signed [15:0] marks;
      logic [63:0]        w [4];
   } outcome_t;

   // table predictor plus queue of pending outcomes
   class table_scoreboard;
      int unsigned chain_len [NUM_BUCKETS];
      record_type  slot [NUM_BUCKETS][DEPTH];
      outcome_t    pending [$];
      int          mismatches;

      function void note_item(cmd_type cmd, logic [6:0] key, logic [15:0] marks,
                              logic [63:0] w0, logic [63:0] w1,
                              logic [63:0] w2, logic [63:0] w3);
         outcome_t o;
         int b;
         int hit;
         int n;
         n = key % 10;
         b = (n == 0) ? 9 : n - 1;
         o.status = ST_OK;
         o.bucket = 4'(b);
         o.key = '0;
         o.marks = '0;
         for (int i = 0; i < 4; i++) o.w[i] = '0;
         hit = -1;
         for (int i = 0; i < int'(chain_len[b]); i++)
            if (hit < 0 && slot[b][i].key == key) hit = i;
         if (cmd == CMD_INSERT) begin
            if (chain_len[b] >= DEPTH) begin
               o.status = ST_FULL;
            end else begin
               slot[b][chain_len[b]] = '{key, marks, w0, w1, w2, w3};
               chain_len[b]++;
               o.key = key;
            end
         end else if (hit < 0) begin
            o.status = ST_NOT_FOUND;
         end else if (cmd == CMD_DELETE) begin
            for (int i = hit; i + 1 < int'(chain_len[b]); i++)
               slot[b][i] = slot[b][i+1];
            chain_len[b]--;
            o.key = key;
         end else begin
            o.key = slot[b][hit].key;
            o.marks = slot[b][hit].marks;
            o.w[0] = slot[b][hit].w0;
            o.w[1] = slot[b][hit].w1;
            o.w[2] = slot[b][hit].w2;
            o.w[3] = slot[b][hit].w3;
         end
         pending.push_back(o);
      endfunction

      function void check_result(logic [1:0] st, logic [3:0] bk, logic [6:0] key,
                                 logic [15:0] marks, logic [63:0] w0,
                                 logic [63:0] w1, logic [63:0] w2,
                                 logic [63:0] w3);
         outcome_t o;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result, status %0d", st);
            return;
         end
         o = pending.pop_front();
         if (st !== o.status || bk !== o.bucket || key !== o.key ||
             marks !== o.marks || w0 !== o.w[0] || w1 !== o.w[1] ||
             w2 !== o.w[2] || w3 !== o.w[3]) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp st %0d b %0d k %0d m %h %h %h %h %h / got st %0d b %0d k %0d m %h %h %h %h %h",
                        o.status, o.bucket, o.key, o.marks, o.w[0], o.w[1], o.w[2],
                        o.w[3], st, bk, key, marks, w0, w1, w2, w3);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1, start = 0;
   logic busy, rsp_valid;
   logic [1:0] req_cmd = '0;
   logic [6:0] req_record_key = '0;
   logic signed [15:0] req_marks_in = '0;
   logic [63:0] req_name_in_w0 = '0, req_name_in_w1 = '0;
   logic [63:0] req_name_in_w2 = '0, req_name_in_w3 = '0;
   logic [1:0] rsp_status;
   logic [3:0] rsp_bucket;
   logic [6:0] rsp_found_key;
   logic signed [15:0] rsp_marks_out;
   logic [63:0] rsp_name_out_w0, rsp_name_out_w1, rsp_name_out_w2, rsp_name_out_w3;

   table_scoreboard board;
   int gap_pct;

   chained_hash_table #(.CHAIN_DEPTH(DEPTH)) dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // results are sampled at the edge that ends their cycle
   always @(posedge clock)
      if (!reset && rsp_valid)
         board.check_result(rsp_status, rsp_bucket, rsp_found_key, rsp_marks_out,
                            rsp_name_out_w0, rsp_name_out_w1, rsp_name_out_w2,
                            rsp_name_out_w3);

   function automatic logic [63:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   // maybe idle, then present one item and hold start until busy drops
   task automatic send_item(cmd_type cmd, logic [6:0] key, logic [15:0] marks,
                            logic [63:0] w0, logic [63:0] w1,
                            logic [63:0] w2, logic [63:0] w3);
      while ($urandom_range(99) < gap_pct) @(posedge clock);
      req_cmd <= cmd;
      req_record_key <= key;
      req_marks_in <= marks;
      req_name_in_w0 <= w0;
      req_name_in_w1 <= w1;
      req_name_in_w2 <= w2;
      req_name_in_w3 <= w3;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_item(cmd, key, marks, w0, w1, w2, w3);
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random(int hot);
      cmd_type c;
      logic [6:0] k;
      int r;
      r = $urandom_range(99);
      c = (r < 45) ? CMD_INSERT : (r < 70) ? CMD_DELETE :
          (r < 95) ? CMD_SEARCH : CMD_SEARCH_ALT;
      // mostly a small key set so chains fill and duplicates hit
      if (hot) k = 7'($urandom_range(7) * 10 + $urandom_range(2) + 1);
      else     k = 7'($urandom_range(127));
      send_item(c, k, 16'($urandom()), rand_word(), rand_word(), rand_word(),
                rand_word());
   endtask

   initial begin
      board = new();
      gap_pct = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: misses on empty table, extremes, full chain, dup, delete order
      send_item(CMD_SEARCH, 7'd0, '0, '0, '0, '0, '0);
      send_item(CMD_DELETE, 7'd99, '0, '0, '0, '0, '0);
      send_item(CMD_INSERT, 7'd0, 16'h8000, '0, '0, '0, '0);
      send_item(CMD_INSERT, 7'd127, 16'h7fff, '1, '1, '1, '1);
      send_item(CMD_SEARCH, 7'd127, '0, '0, '0, '0, '0);
      send_item(CMD_SEARCH_ALT, 7'd0, '0, '0, '0, '0, '0);
      for (int i = 0; i < 9; i++)
         send_item(CMD_INSERT, (i % 2) ? 7'd15 : 7'd25, 16'(i), rand_word(),
                   rand_word(), rand_word(), rand_word());
      send_item(CMD_SEARCH, 7'd15, '0, '0, '0, '0, '0);
      send_item(CMD_DELETE, 7'd25, '0, '0, '0, '0, '0);
      send_item(CMD_SEARCH, 7'd25, '0, '0, '0, '0, '0);
      send_item(CMD_DELETE, 7'd15, '0, '0, '0, '0, '0);
      send_item(CMD_SEARCH, 7'd15, '0, '0, '0, '0, '0);
      send_item(CMD_SEARCH, 7'd5, '0, '0, '0, '0, '0);

      // random phases: sender idles lightly, then heavily, then not at all
      gap_pct = 14;
      repeat (550) send_random($urandom_range(9) < 8);
      gap_pct = 56;
      repeat (550) send_random($urandom_range(9) < 8);
      gap_pct = 0;
      repeat (550) send_random($urandom_range(9) < 8);

      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
